[rtl/ffra_pkg.sv]
// Package for the first-fit range allocator: status codes and operation codes.
// No dependencies.
`timescale 1ns / 1ps
package ffra_pkg;
   localparam logic [0:0] OP_ALLOC   = 1'b0;
   localparam logic [0:0] OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;
endpackage

[rtl/ffra_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered
// read. No dependencies.
`timescale 1ns / 1ps
module ffra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/first_fit_range_allocator.sv]
// First-fit range allocator: top level with control sequencer and two table RAMs.
// Depends on ffra_pkg and ffra_ram.
// A zero-length request goes straight to the result; allocate and release scan the
// table first. Busy drops in the cycle after the strobe; only then is a new one taken.
// Result strobed for one cycle, the receiver cannot stall. Synchronous reset empties
// the table, zeroes the cursor and sets capacity to 2^ADDRESS_BITS.
`timescale 1ns / 1ps
module first_fit_range_allocator #(
   parameter int MAX_FREE_RANGES = 16,
   parameter int ADDRESS_BITS    = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_operation,
   input  logic [ADDRESS_BITS:0]   req_range_length,
   input  logic [ADDRESS_BITS-1:0] req_release_offset,
   input  logic                    csr_wr_en,
   input  logic [ADDRESS_BITS:0]   csr_wr_data,
   output logic                    rsp_valid,
   output logic [ADDRESS_BITS-1:0] rsp_granted_offset,
   output logic [1:0]              rsp_status
);
   localparam int IW = $clog2(MAX_FREE_RANGES);
   localparam int CW = $clog2(MAX_FREE_RANGES + 2);
   localparam int LW = ADDRESS_BITS + 1;
   localparam int AW = ADDRESS_BITS;
   localparam logic [LW-1:0] SPACE = {1'b1, {AW{1'b0}}};
   localparam logic [CW-1:0] MAXN  = CW'(MAX_FREE_RANGES);

   // Release works in two passes: pass 1 counts merged entries (dry run), pass 2
   // writes merged entries back. Both scan old table plus inserted range in order.
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_ARD   = 10'b0000000010,
      S_ACHK  = 10'b0000000100,
      S_SHRD  = 10'b0000001000,
      S_SHWR  = 10'b0000010000,
      S_RRD   = 10'b0000100000,
      S_RCHK  = 10'b0001000000,
      S_RFIN  = 10'b0010000000,
      S_RESP  = 10'b0100000000,
      S_SPARE = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [LW-1:0] cap_ff, cap_in, cur_ff, cur_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          op_ff, op_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] off_ff, off_in;
   logic [CW-1:0] idx_ff, idx_in;     // read index into old table
   logic [CW-1:0] wix_ff, wix_in;     // write index / merged count
   logic          pass_ff, pass_in;   // 0 count, 1 write
   logic          placed_ff, placed_in;
   logic          have_ff, have_in;   // accumulator holds an entry
   logic [LW-1:0] acs_ff, acs_in;     // accumulator start (LW for end math)
   logic [LW-1:0] ace_ff, ace_in;     // accumulator end
   logic [AW-1:0] res_off_ff, res_off_in;
   logic [1:0]    res_st_ff, res_st_in;

   logic          we;
   logic [IW-1:0] wa, ra;
   logic [AW-1:0] ws, rs;
   logic [LW-1:0] wl, rl;

   ffra_ram #(.WIDTH(AW), .DEPTH(MAX_FREE_RANGES)) u_start (
      .clock, .wr_en(we), .wr_addr(wa), .wr_data(ws), .rd_addr(ra), .rd_data(rs));
   ffra_ram #(.WIDTH(LW), .DEPTH(MAX_FREE_RANGES)) u_len (
      .clock, .wr_en(we), .wr_addr(wa), .wr_data(wl), .rd_addr(ra), .rd_data(rl));

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_granted_offset = res_off_ff;
   assign rsp_status = res_st_ff;

   logic [LW-1:0] limit, rl_rem, rel_len, cand_s, cand_e;
   logic          use_new, old_left;

   always_comb begin
      limit   = (cap_ff < SPACE) ? cap_ff : SPACE;
      rl_rem  = rl - len_ff;
      rel_len = (len_ff > SPACE - {1'b0, off_ff}) ? SPACE - {1'b0, off_ff} : len_ff;
      old_left = (idx_ff < cnt_ff);
      use_new  = !placed_ff && (!old_left || {1'b0, rs} > {1'b0, off_ff});
      cand_s   = use_new ? {1'b0, off_ff} : {1'b0, rs};
      cand_e   = use_new ? {1'b0, off_ff} + rel_len : {1'b0, rs} + rl;

      state_in = state_ff; cap_in = cap_ff; cur_in = cur_ff; cnt_in = cnt_ff;
      op_in = op_ff; len_in = len_ff; off_in = off_ff; idx_in = idx_ff;
      wix_in = wix_ff; pass_in = pass_ff; placed_in = placed_ff; have_in = have_ff;
      acs_in = acs_ff; ace_in = ace_ff; res_off_in = res_off_ff; res_st_in = res_st_ff;
      we = 1'b0; wa = wix_ff[IW-1:0]; ws = rs; wl = rl; ra = idx_ff[IW-1:0];

      if (csr_wr_en) cap_in = csr_wr_data;

      case (state_ff)
         S_IDLE: begin
            idx_in = '0; wix_in = '0; pass_in = 1'b0; placed_in = 1'b0; have_in = 1'b0;
            ra = '0;
            if (start) begin
               op_in = req_operation; len_in = req_range_length;
               off_in = req_release_offset;
               res_off_in = '0; res_st_in = ffra_pkg::STATUS_OK;
               if (req_range_length == '0) state_in = S_RESP;
               else if (req_operation == ffra_pkg::OP_ALLOC) state_in = S_ARD;
               else state_in = S_RRD;
            end
         end
         S_ARD: state_in = S_ACHK; // wait for read data
         S_ACHK: begin
            if (old_left) begin
               if (rl >= len_ff) begin
                  res_off_in = rs;
                  if (rl_rem == '0) begin
                     // drop: shift later entries down
                     wix_in = idx_ff; idx_in = idx_ff + 1'b1;
                     cnt_in = cnt_ff - 1'b1;
                     state_in = S_SHRD;
                  end else begin
                     we = 1'b1; wa = idx_ff[IW-1:0];
                     ws = rs + len_ff[AW-1:0]; wl = rl_rem;
                     state_in = S_RESP;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1; state_in = S_ARD;
               end
            end else if (cur_ff > limit || len_ff > limit - cur_ff) begin
               res_st_in = ffra_pkg::STATUS_NO_SPACE;
               state_in = S_RESP;
            end else begin
               res_off_in = cur_ff[AW-1:0]; cur_in = cur_ff + len_ff;
               state_in = S_RESP;
            end
         end
         S_SHRD: begin
            // idx_ff points at source; cnt already reduced, so source < cnt+1
            if (idx_ff <= cnt_ff) state_in = S_SHWR;
            else state_in = S_RESP;
         end
         S_SHWR: begin
            we = 1'b1; wa = wix_ff[IW-1:0];
            wix_in = wix_ff + 1'b1; idx_in = idx_ff + 1'b1;
            state_in = S_SHRD;
         end
         S_RRD: state_in = S_RCHK;
         S_RCHK: begin
            if (!old_left && placed_ff) begin
               state_in = S_RFIN;
            end else begin
               if (use_new) placed_in = 1'b1;
               else idx_in = idx_ff + 1'b1;
               if (have_ff && ace_ff >= cand_s) begin
                  if (cand_e > ace_ff) ace_in = cand_e;
               end else begin
                  // emit accumulator, start new one
                  if (have_ff) begin
                     if (pass_ff) begin
                        we = 1'b1; wa = wix_ff[IW-1:0];
                        ws = acs_ff[AW-1:0]; wl = ace_ff - acs_ff;
                     end
                     wix_in = wix_ff + 1'b1;
                  end
                  have_in = 1'b1; acs_in = cand_s; ace_in = cand_e;
               end
               // pass 2 writes never overtake reads: wix <= idx always holds
               state_in = S_RRD;
               ra = use_new ? idx_ff[IW-1:0] : IW'(idx_ff + 1'b1);
            end
         end
         S_RFIN: begin
            if (!pass_ff) begin
               if (wix_ff + 1'b1 > MAXN) begin
                  res_st_in = ffra_pkg::STATUS_FULL;
                  state_in = S_RESP;
               end else begin
                  pass_in = 1'b1; idx_in = '0; wix_in = '0; placed_in = 1'b0;
                  have_in = 1'b0; ra = '0; state_in = S_RRD;
               end
            end else begin
               we = 1'b1; wa = wix_ff[IW-1:0];
               ws = acs_ff[AW-1:0]; wl = ace_ff - acs_ff;
               cnt_in = wix_ff + 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cap_ff <= SPACE; cur_ff <= '0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; cap_ff <= cap_in; cur_ff <= cur_in; cnt_ff <= cnt_in;
      end
      op_ff <= op_in; len_ff <= len_in; off_ff <= off_in; idx_ff <= idx_in;
      wix_ff <= wix_in; pass_ff <= pass_in; placed_ff <= placed_in; have_ff <= have_in;
      acs_ff <= acs_in; ace_ff <= ace_in; res_off_ff <= res_off_in;
      res_st_ff <= res_st_in;
   end
endmodule
